// ===== hw/rtl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, constants and the blend function of the trilinear sampler.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int MAX_DIM_DEFAULT = 32;
    localparam int SIZE_W          = 6;
    localparam int ORG_W           = 16;
    localparam int VAL_W           = 32;
    localparam int FRAC_W          = 16;
    localparam int ADDR_W          = 15;
    localparam int STORE_DEPTH     = 1 << ADDR_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd5;

    localparam logic signed [VAL_W-1:0] EMPTY_DISTANCE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     operation;
        logic [ADDR_W-1:0]        voxel_index;
        logic signed [VAL_W-1:0]  voxel_value;
        logic signed [VAL_W-1:0]  point_x;
        logic signed [VAL_W-1:0]  point_y;
        logic signed [VAL_W-1:0]  point_z;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  distance;
        logic                     empty_grid;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // a + floor(((b - a) * f + 2^15) / 2^16)
    function automatic logic signed [VAL_W-1:0] blend(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic [FRAC_W-1:0]       f
    );
        logic signed [VAL_W:0]          diff;
        logic signed [VAL_W+FRAC_W+1:0] prod;
        logic signed [VAL_W+FRAC_W+1:0] sh;
        diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
        prod = (VAL_W+FRAC_W+2)'(diff) * (VAL_W+FRAC_W+2)'($signed({1'b0, f}));
        sh   = (prod + (VAL_W+FRAC_W+2)'(32768)) >>> FRAC_W;
        return a + sh[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tsg_stream_if.sv =====
// ----------------------------------------------------------------------------
// tsg_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface tsg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tsg_ram.sv =====
// ----------------------------------------------------------------------------
// tsg_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/tsg_axis.sv =====
// ----------------------------------------------------------------------------
// tsg_axis
// One axis: origin offset, clamp to the grid, lower/upper corner, fraction.
// ----------------------------------------------------------------------------
module tsg_axis (
    input  logic signed [tsg_pkg::VAL_W-1:0] point,
    input  logic signed [tsg_pkg::ORG_W-1:0] origin,
    input  logic [tsg_pkg::SIZE_W-1:0]       size,
    output tsg_pkg::axis_t                   axis
);
    import tsg_pkg::*;

    localparam int D_W = VAL_W + 2;
    localparam int C_W = SIZE_W + FRAC_W;

    logic signed [D_W-1:0] d;
    logic signed [D_W-1:0] top;
    logic [C_W-1:0]        clamped;
    logic [SIZE_W:0]       lo_inc;
    logic [SIZE_W-1:0]     size_m1;

    always_comb
    begin
        size_m1 = size - SIZE_W'(1);
        d       = D_W'(point) - (D_W'(origin) <<< FRAC_W);
        top     = D_W'($signed({1'b0, size_m1, {FRAC_W{1'b0}}}));
        if (d < 0)
        begin
            clamped = '0;
        end
        else if (d > top)
        begin
            clamped = top[C_W-1:0];
        end
        else
        begin
            clamped = d[C_W-1:0];
        end
        axis.lo   = clamped[C_W-1:FRAC_W];
        axis.frac = clamped[FRAC_W-1:0];
        lo_inc    = {1'b0, axis.lo} + (SIZE_W+1)'(1);
        axis.hi   = (lo_inc < {1'b0, size}) ? lo_inc[SIZE_W-1:0] : size_m1;
    end
endmodule

// ===== hw/rtl/trilinear_grid_sampler_core.sv =====
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_core
// Trilinear sampling of a Q16.16 signed-distance grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   items   : input beats. operation 0 loads voxel_value at voxel_index and
//             returns nothing; operation 1 queries point_x/y/z and returns one
//             beat on results.
//   results : distance (Q16.16) and empty_grid. An empty grid (a size zero or
//             nothing loaded) returns the largest positive distance, flag set.
//   cfg_*   : register write port (sizes, origins); write only while idle.
// Throughput: one beat per cycle unless stalled. One RAM copy per cube corner
//   gives the eight reads in a single cycle; every load writes all copies.
// Pipeline registers: axis split, row index, address, RAM read, x blend,
//   y blend, z blend into the output register.
// Reset: configuration clears to zero, the loaded flag clears, pipeline empty.
//   RAM contents are undefined until written; no clearing pass.
// Stall: the whole pipeline holds while results is stalled and its output
//   register is full; items.ready drops then, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_core #(
    parameter int MAX_DIM = tsg_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    tsg_stream_if.sink                        items,
    tsg_stream_if.source                      results
);
    import tsg_pkg::*;

    localparam int ROW_N  = 4;
    localparam int CORN_N = 8;

    logic [SIZE_W-1:0]       size_x_reg, size_y_reg, size_z_reg;
    logic signed [ORG_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic                    grid_loaded_reg;

    logic [SIZE_W-1:0] sx, sy, sz;
    logic              adv;
    logic              accept;
    logic              empty_now;
    axis_t             ax, ay, az;

    // stage 1
    logic              s1_valid_reg;
    logic              s1_op_reg, s1_empty_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    axis_t             s1_ax_reg, s1_ay_reg, s1_az_reg;
    // stage 2
    logic              s2_valid_reg;
    logic              s2_op_reg, s2_empty_reg;
    logic [ADDR_W-1:0] s2_idx_reg;
    logic [VAL_W-1:0]  s2_val_reg;
    axis_t             s2_ax_reg;
    logic [FRAC_W-1:0] s2_fy_reg, s2_fz_reg;
    logic [ADDR_W-1:0] s2_row_reg [ROW_N];
    // stage 3
    logic              s3_valid_reg;
    logic              s3_op_reg, s3_empty_reg;
    logic [ADDR_W-1:0] s3_idx_reg;
    logic [VAL_W-1:0]  s3_val_reg;
    logic [FRAC_W-1:0] s3_fx_reg, s3_fy_reg, s3_fz_reg;
    logic [ADDR_W-1:0] s3_addr_reg [CORN_N];
    // stage 4 (RAM data)
    logic              s4_valid_reg;
    logic              s4_op_reg, s4_empty_reg;
    logic [FRAC_W-1:0] s4_fx_reg, s4_fy_reg, s4_fz_reg;
    logic [VAL_W-1:0]  corner [CORN_N];
    // stage 5
    logic                    s5_valid_reg;
    logic                    s5_op_reg, s5_empty_reg;
    logic [FRAC_W-1:0]       s5_fy_reg, s5_fz_reg;
    logic signed [VAL_W-1:0] s5_c_reg [ROW_N];
    // stage 6
    logic                    s6_valid_reg;
    logic                    s6_op_reg, s6_empty_reg;
    logic [FRAC_W-1:0]       s6_fz_reg;
    logic signed [VAL_W-1:0] s6_c0_reg, s6_c1_reg;
    // output
    logic                    out_valid_reg;
    result_t                 out_data_reg;

    logic ram_we, ram_re;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (int'(s) > MAX_DIM) ? SIZE_W'(MAX_DIM) : s;
    endfunction

    assign sx = eff_size(size_x_reg);
    assign sy = eff_size(size_y_reg);
    assign sz = eff_size(size_z_reg);

    assign adv          = !out_valid_reg || results.ready;
    assign items.ready  = adv;
    assign accept       = items.valid && adv;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    assign empty_now = (sx == '0) || (sy == '0) || (sz == '0) || !grid_loaded_reg;

    // configuration and loaded flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= '0;
            size_y_reg      <= '0;
            size_z_reg      <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            grid_loaded_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIZE_X:   size_x_reg   <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_Y:   size_y_reg   <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_Z:   size_z_reg   <= cfg_data[SIZE_W-1:0];
                    REG_ORIGIN_X: origin_x_reg <= $signed(cfg_data[ORG_W-1:0]);
                    REG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data[ORG_W-1:0]);
                    REG_ORIGIN_Z: origin_z_reg <= $signed(cfg_data[ORG_W-1:0]);
                    default: ;
                endcase
            end
            if (accept && items.data.operation == OP_LOAD)
            begin
                grid_loaded_reg <= 1'b1;
            end
        end
    end

    tsg_axis u_axis_x (.point(items.data.point_x), .origin(origin_x_reg), .size(sx), .axis(ax));
    tsg_axis u_axis_y (.point(items.data.point_y), .origin(origin_y_reg), .size(sy), .axis(ay));
    tsg_axis u_axis_z (.point(items.data.point_z), .origin(origin_z_reg), .size(sz), .axis(az));

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= items.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg && (s6_op_reg == OP_QUERY);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= items.data.operation;
            s1_empty_reg <= empty_now;
            s1_idx_reg   <= items.data.voxel_index;
            s1_val_reg   <= items.data.voxel_value;
            s1_ax_reg    <= ax;
            s1_ay_reg    <= ay;
            s1_az_reg    <= az;

            s2_op_reg    <= s1_op_reg;
            s2_empty_reg <= s1_empty_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
            s2_ax_reg    <= s1_ax_reg;
            s2_fy_reg    <= s1_ay_reg.frac;
            s2_fz_reg    <= s1_az_reg.frac;
            for (int j = 0; j < ROW_N; j++)
            begin
                s2_row_reg[j] <= ADDR_W'(j[0] ? s1_ay_reg.hi : s1_ay_reg.lo)
                    + ADDR_W'(sy) * ADDR_W'(j[1] ? s1_az_reg.hi : s1_az_reg.lo);
            end

            s3_op_reg    <= s2_op_reg;
            s3_empty_reg <= s2_empty_reg;
            s3_idx_reg   <= s2_idx_reg;
            s3_val_reg   <= s2_val_reg;
            s3_fx_reg    <= s2_ax_reg.frac;
            s3_fy_reg    <= s2_fy_reg;
            s3_fz_reg    <= s2_fz_reg;
            for (int k = 0; k < CORN_N; k++)
            begin
                s3_addr_reg[k] <= ADDR_W'(k[0] ? s2_ax_reg.hi : s2_ax_reg.lo)
                    + ADDR_W'(sx) * s2_row_reg[k >> 1];
            end

            s4_op_reg    <= s3_op_reg;
            s4_empty_reg <= s3_empty_reg;
            s4_fx_reg    <= s3_fx_reg;
            s4_fy_reg    <= s3_fy_reg;
            s4_fz_reg    <= s3_fz_reg;

            s5_op_reg    <= s4_op_reg;
            s5_empty_reg <= s4_empty_reg;
            s5_fy_reg    <= s4_fy_reg;
            s5_fz_reg    <= s4_fz_reg;
            for (int j = 0; j < ROW_N; j++)
            begin
                s5_c_reg[j] <= blend($signed(corner[2*j]), $signed(corner[2*j+1]), s4_fx_reg);
            end

            s6_op_reg    <= s5_op_reg;
            s6_empty_reg <= s5_empty_reg;
            s6_fz_reg    <= s5_fz_reg;
            s6_c0_reg    <= blend(s5_c_reg[0], s5_c_reg[1], s5_fy_reg);
            s6_c1_reg    <= blend(s5_c_reg[2], s5_c_reg[3], s5_fy_reg);

            out_data_reg.empty_grid <= s6_empty_reg;
            out_data_reg.distance   <= s6_empty_reg ? EMPTY_DISTANCE
                                     : blend(s6_c0_reg, s6_c1_reg, s6_fz_reg);
        end
    end

    // one RAM copy per corner; loads write all copies at the read stage
    assign ram_we = adv && s3_valid_reg && (s3_op_reg == OP_LOAD);
    assign ram_re = adv && s3_valid_reg && (s3_op_reg == OP_QUERY);

    for (genvar g = 0; g < CORN_N; g++)
    begin : g_bank
        tsg_ram #(
            .WIDTH (VAL_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (s3_idx_reg),
            .wdata (s3_val_reg),
            .re    (ram_re),
            .raddr (s3_addr_reg[g]),
            .rdata (corner[g])
        );
    end

    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM write and read in the same cycle");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.empty_grid |-> results.data.distance == EMPTY_DISTANCE)
        else $error("empty grid beat without max distance");

    a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        grid_loaded_reg |=> grid_loaded_reg)
        else $error("loaded flag cleared");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s6_valid_reg && (s6_op_reg == OP_LOAD) |=> !out_valid_reg)
        else $error("load produced a result beat");
endmodule
